// ----- hw/rtl/asf_pkg.sv -----
`timescale 1ns / 1ps

package asf_pkg;

	localparam int POS_W     = 32;
	localparam int ROT_W     = 16;
	localparam int ROT_FRAC  = 14;
	localparam int PROD_W    = POS_W + ROT_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int K_W       = 31;
	localparam int D_W       = POS_W + 1;
	localparam int SQR_W     = 2 * D_W;
	localparam int LEN_W     = D_W;
	localparam int SQ_STEPS  = LEN_W;
	localparam int SQ_REM_W  = LEN_W + 4;
	localparam int DIFF_W    = LEN_W + 1;
	localparam int P_W       = 64;
	localparam int U_W       = D_W;
	localparam int DV_STEPS  = U_W;
	localparam int PP_W      = U_W + 32;
	localparam int FP_W      = U_W + P_W;
	localparam int MAG_W     = FP_W - 48;
	localparam int LATENCY   = 4 + (SQ_STEPS + 1) + (DV_STEPS + 1) + 2;

	localparam logic [POS_W-1:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [POS_W-1:0] S32_MIN = 32'h8000_0000;
	localparam logic [K_W-1:0]   K_RESET = 31'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANCHOR_X = 3'd0,
		REG_ANCHOR_Y = 3'd1,
		REG_ANCHOR_Z = 3'd2,
		REG_STIFF    = 3'd3,
		REG_REST     = 3'd4,
		REG_OFF_X    = 3'd5,
		REG_OFF_Y    = 3'd6,
		REG_OFF_Z    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] point;
		logic [2:0][D_W-1:0]   absd;
		logic [2:0]            dneg;
	} sq_carry_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] point;
		logic [2:0]            bit0;
		logic [2:0]            dneg;
		logic [LEN_W-1:0]      len;
		logic [P_W-1:0]        p;
		logic                  diffneg;
		logic                  degen;
	} dv_carry_t;

endpackage

// ----- hw/rtl/anchored_spring_force_top.sv -----
`timescale 1ns / 1ps

// Hooke spring between one rigid body and a fixed world anchor. One transaction
// per cycle is accepted while the output is not stalled; each gives exactly one
// result, in order. Most of the pipeline is the one-bit-per-stage square root
// (34 stages) and the three parallel one-bit-per-stage dividers (34 stages).
// A stalled output holds the whole pipeline; bubbles flow through freely.
// Configuration writes take effect at once and must only happen when idle.
module anchored_spring_force_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [asf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [asf_pkg::POS_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [asf_pkg::POS_W-1:0]    pos_x,
	input  logic signed [asf_pkg::POS_W-1:0]    pos_y,
	input  logic signed [asf_pkg::POS_W-1:0]    pos_z,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_00,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_01,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_02,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_10,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_11,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_12,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_20,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_21,
	input  logic signed [asf_pkg::ROT_W-1:0]    rot_22,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [asf_pkg::POS_W-1:0]    force_x,
	output logic signed [asf_pkg::POS_W-1:0]    force_y,
	output logic signed [asf_pkg::POS_W-1:0]    force_z,
	output logic signed [asf_pkg::POS_W-1:0]    point_x,
	output logic signed [asf_pkg::POS_W-1:0]    point_y,
	output logic signed [asf_pkg::POS_W-1:0]    point_z,
	output logic                                degenerate
);

	localparam int PW  = asf_pkg::POS_W;
	localparam int SQN = asf_pkg::SQ_STEPS;
	localparam int DVN = asf_pkg::DV_STEPS;
	localparam int LW  = asf_pkg::LEN_W;

	// configuration
	logic signed [PW-1:0]        anchor_q [3];
	logic signed [PW-1:0]        off_q [3];
	logic [asf_pkg::K_W-1:0]     stiff_q;
	logic [asf_pkg::K_W-1:0]     rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				anchor_q[i] <= '0;
				off_q[i]    <= '0;
			end
			stiff_q <= asf_pkg::K_RESET;
			rest_q  <= '0;
		end else if (cfg_we) begin
			case (asf_pkg::cfg_reg_t'(cfg_index))
				asf_pkg::REG_ANCHOR_X: anchor_q[0] <= cfg_data;
				asf_pkg::REG_ANCHOR_Y: anchor_q[1] <= cfg_data;
				asf_pkg::REG_ANCHOR_Z: anchor_q[2] <= cfg_data;
				asf_pkg::REG_STIFF:    stiff_q     <= cfg_data[asf_pkg::K_W-1:0];
				asf_pkg::REG_REST:     rest_q      <= cfg_data[asf_pkg::K_W-1:0];
				asf_pkg::REG_OFF_X:    off_q[0]    <= cfg_data;
				asf_pkg::REG_OFF_Y:    off_q[1]    <= cfg_data;
				asf_pkg::REG_OFF_Z:    off_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: everything advances unless the output holds a stalled result
	logic                          adv;
	logic [asf_pkg::LATENCY-1:0]   vld_q;

	assign adv      = !(vld_q[asf_pkg::LATENCY-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[asf_pkg::LATENCY-2:0], in_valid};
	end

	logic signed [asf_pkg::ROT_W-1:0] rot [3][3];
	logic signed [PW-1:0]             pos [3];

	always_comb begin
		rot[0][0] = rot_00; rot[0][1] = rot_01; rot[0][2] = rot_02;
		rot[1][0] = rot_10; rot[1][1] = rot_11; rot[1][2] = rot_12;
		rot[2][0] = rot_20; rot[2][1] = rot_21; rot[2][2] = rot_22;
		pos[0] = pos_x; pos[1] = pos_y; pos[2] = pos_z;
	end

	// s1: basis times offset
	logic signed [asf_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic signed [PW-1:0]              pos_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pos[i];
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= asf_pkg::PROD_W'(rot[i][j])
						* asf_pkg::PROD_W'(off_q[j]);
			end
		end
	end

	// s2: round, add position, saturate
	logic signed [asf_pkg::ACC_W-1:0] acc [3];
	logic signed [asf_pkg::ACC_W-1:0] rnd [3];
	logic signed [asf_pkg::ACC_W:0]   pt_wide [3];
	logic [PW-1:0]                    point_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = asf_pkg::ACC_W'(prod_s1[i][0]) + asf_pkg::ACC_W'(prod_s1[i][1])
				+ asf_pkg::ACC_W'(prod_s1[i][2])
				+ asf_pkg::ACC_W'(1 << (asf_pkg::ROT_FRAC - 1));
			rnd[i] = acc[i] >>> asf_pkg::ROT_FRAC;
			pt_wide[i] = (asf_pkg::ACC_W+1)'(rnd[i]) + (asf_pkg::ACC_W+1)'(pos_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (pt_wide[i] > (asf_pkg::ACC_W+1)'($signed(asf_pkg::S32_MAX)))
					point_s2[i] <= asf_pkg::S32_MAX;
				else if (pt_wide[i] < (asf_pkg::ACC_W+1)'($signed(asf_pkg::S32_MIN)))
					point_s2[i] <= asf_pkg::S32_MIN;
				else
					point_s2[i] <= pt_wide[i][PW-1:0];
			end
		end
	end

	// s3: displacement
	logic signed [asf_pkg::D_W-1:0] dsp [3];
	logic [asf_pkg::D_W-1:0]        absd_s3 [3];
	logic [2:0]                     dneg_s3;
	logic [PW-1:0]                  point_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dsp[i] = asf_pkg::D_W'(anchor_q[i]) - asf_pkg::D_W'($signed(point_s2[i]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				point_s3[i] <= point_s2[i];
				dneg_s3[i]  <= dsp[i][asf_pkg::D_W-1];
				absd_s3[i]  <= dsp[i][asf_pkg::D_W-1] ? asf_pkg::D_W'(-dsp[i])
					: asf_pkg::D_W'(dsp[i]);
			end
		end
	end

	// s4: squares
	logic [asf_pkg::SQR_W-1:0] sqr_s4 [3];
	asf_pkg::sq_carry_t        c_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s4[i]     <= asf_pkg::SQR_W'(absd_s3[i]) * asf_pkg::SQR_W'(absd_s3[i]);
				c_s4.point[i] <= point_s3[i];
				c_s4.absd[i]  <= absd_s3[i];
				c_s4.dneg[i]  <= dneg_s3[i];
			end
		end
	end

	// square root pipeline, stage 0 holds the sum of squares
	logic [asf_pkg::SQR_W-1:0]    sq_rad_s5 [SQN+1];
	logic [asf_pkg::SQ_REM_W-1:0] sq_rem_s5 [SQN+1];
	logic [LW-1:0]                sq_root_s5 [SQN+1];
	asf_pkg::sq_carry_t           sq_c_s5 [SQN+1];
	logic [asf_pkg::SQ_REM_W-1:0] sq_sh [SQN];
	logic [asf_pkg::SQ_REM_W-1:0] sq_try [SQN];

	always_comb begin
		for (int k = 0; k < SQN; k++) begin
			sq_sh[k]  = {sq_rem_s5[k][asf_pkg::SQ_REM_W-3:0],
				sq_rad_s5[k][asf_pkg::SQR_W-1-2*k -: 2]};
			sq_try[k] = asf_pkg::SQ_REM_W'({sq_root_s5[k], 2'b01});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rad_s5[0]  <= sqr_s4[0] + sqr_s4[1] + sqr_s4[2];
			sq_rem_s5[0]  <= '0;
			sq_root_s5[0] <= '0;
			sq_c_s5[0]    <= c_s4;
			for (int k = 0; k < SQN; k++) begin
				sq_rad_s5[k+1] <= sq_rad_s5[k];
				sq_c_s5[k+1]   <= sq_c_s5[k];
				if (sq_sh[k] >= sq_try[k]) begin
					sq_rem_s5[k+1]  <= sq_sh[k] - sq_try[k];
					sq_root_s5[k+1] <= {sq_root_s5[k][LW-2:0], 1'b1};
				end else begin
					sq_rem_s5[k+1]  <= sq_sh[k];
					sq_root_s5[k+1] <= {sq_root_s5[k][LW-2:0], 1'b0};
				end
			end
		end
	end

	// divider pipeline, stage 0 forms the spring magnitude P
	logic [LW-1:0]                   len_w;
	logic signed [asf_pkg::DIFF_W-1:0] diff_w;
	logic [asf_pkg::DIFF_W-1:0]      adiff_w;

	assign len_w   = sq_root_s5[SQN];
	assign diff_w  = $signed({1'b0, len_w}) - $signed(asf_pkg::DIFF_W'(rest_q));
	assign adiff_w = diff_w[asf_pkg::DIFF_W-1] ? asf_pkg::DIFF_W'(-diff_w)
		: asf_pkg::DIFF_W'(diff_w);

	logic [LW-1:0]             dv_rem_s6 [DVN+1][3];
	logic [asf_pkg::U_W-1:0]   dv_q_s6 [DVN+1][3];
	asf_pkg::dv_carry_t        dv_c_s6 [DVN+1];
	logic [LW:0]               dv_sh [DVN][3];

	always_comb begin
		for (int k = 0; k < DVN; k++)
			for (int i = 0; i < 3; i++)
				dv_sh[k][i] = {dv_rem_s6[k][i],
					(k == 0) ? dv_c_s6[k].bit0[i] : 1'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s6[0][i]     <= LW'(sq_c_s5[SQN].absd[i] >> 1);
				dv_q_s6[0][i]       <= '0;
				dv_c_s6[0].point[i] <= sq_c_s5[SQN].point[i];
				dv_c_s6[0].bit0[i]  <= sq_c_s5[SQN].absd[i][0];
				dv_c_s6[0].dneg[i]  <= sq_c_s5[SQN].dneg[i];
			end
			dv_c_s6[0].len     <= len_w;
			dv_c_s6[0].p       <= asf_pkg::P_W'(stiff_q) * asf_pkg::P_W'(adiff_w);
			dv_c_s6[0].diffneg <= diff_w[asf_pkg::DIFF_W-1];
			dv_c_s6[0].degen   <= (len_w == '0);
			for (int k = 0; k < DVN; k++) begin
				dv_c_s6[k+1] <= dv_c_s6[k];
				for (int i = 0; i < 3; i++) begin
					if (dv_sh[k][i] >= {1'b0, dv_c_s6[k].len}) begin
						dv_rem_s6[k+1][i] <= LW'(dv_sh[k][i] - {1'b0, dv_c_s6[k].len});
						dv_q_s6[k+1][i]   <= {dv_q_s6[k][i][asf_pkg::U_W-2:0], 1'b1};
					end else begin
						dv_rem_s6[k+1][i] <= LW'(dv_sh[k][i]);
						dv_q_s6[k+1][i]   <= {dv_q_s6[k][i][asf_pkg::U_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// s7: u times P, split in halves
	logic [asf_pkg::PP_W-1:0] pp_lo_s7 [3];
	logic [asf_pkg::PP_W-1:0] pp_hi_s7 [3];
	logic [2:0]               neg_s7;
	logic                     degen_s7;
	logic [PW-1:0]            point_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pp_lo_s7[i] <= asf_pkg::PP_W'(dv_q_s6[DVN][i])
					* asf_pkg::PP_W'(dv_c_s6[DVN].p[31:0]);
				pp_hi_s7[i] <= asf_pkg::PP_W'(dv_q_s6[DVN][i])
					* asf_pkg::PP_W'(dv_c_s6[DVN].p[63:32]);
				neg_s7[i]   <= dv_c_s6[DVN].dneg[i] ^ dv_c_s6[DVN].diffneg;
				point_s7[i] <= dv_c_s6[DVN].point[i];
			end
			degen_s7 <= dv_c_s6[DVN].degen;
		end
	end

	// s8: combine, scale, sign, saturate
	logic [asf_pkg::FP_W-1:0]  fp [3];
	logic [asf_pkg::MAG_W-1:0] mag [3];
	logic [PW-1:0]             frc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fp[i]  = {pp_hi_s7[i], 32'b0} + asf_pkg::FP_W'(pp_lo_s7[i]);
			mag[i] = fp[i][asf_pkg::FP_W-1:48];
			if (degen_s7)
				frc[i] = '0;
			else if (neg_s7[i])
				frc[i] = (mag[i] >= asf_pkg::MAG_W'(asf_pkg::S32_MIN)) ? asf_pkg::S32_MIN
					: PW'(-mag[i]);
			else
				frc[i] = (mag[i] > asf_pkg::MAG_W'(asf_pkg::S32_MAX)) ? asf_pkg::S32_MAX
					: mag[i][PW-1:0];
		end
	end

	logic [PW-1:0] force_s8 [3];
	logic [PW-1:0] point_s8 [3];
	logic          degen_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				force_s8[i] <= frc[i];
				point_s8[i] <= point_s7[i];
			end
			degen_s8 <= degen_s7;
		end
	end

	assign out_valid  = vld_q[asf_pkg::LATENCY-1];
	assign force_x    = force_s8[0];
	assign force_y    = force_s8[1];
	assign force_z    = force_s8[2];
	assign point_x    = point_s8[0];
	assign point_y    = point_s8[1];
	assign point_z    = point_s8[2];
	assign degenerate = degen_s8;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> force_x == '0 && force_y == '0 && force_z == '0)
		else $error("degenerate result with nonzero force");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(point_x))
		else $error("stalled result changed");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_c_s6[0].degen |-> dv_c_s6[0].len == '0)
		else $error("degenerate flag with nonzero length");

endmodule
